/* src/ufd_pkg.sv */
package ufd_pkg;

   // field widths
   localparam int CP_BITS     = 21;
   localparam int LINE_BITS   = 20;
   localparam int COL_BITS    = 16;
   localparam int OFFSET_BITS = 32;
   localparam int BYTE_BITS   = 8;

   // result beat layout
   localparam int RSP_BITS       = CP_BITS + LINE_BITS + COL_BITS + OFFSET_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - RSP_BITS;

   // job queue between front and back
   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   localparam logic [CP_BITS-1:0] CP_REPL    = 21'h00FFFD;
   localparam logic [CP_BITS-1:0] CP_NEWLINE = 21'h00000A;

   // byte masks
   localparam logic [BYTE_BITS-1:0] MASK_LEAD2 = 8'h1F;
   localparam logic [BYTE_BITS-1:0] MASK_LEAD3 = 8'h0F;
   localparam logic [BYTE_BITS-1:0] MASK_LEAD4 = 8'h07;

   // sequence length codes
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   // work for one input byte: a run of replacements from a broken or cut
   // sequence, then at most one character or one trailing replacement
   typedef struct packed {
      logic                   is_last;
      logic                   fl_valid;
      logic [1:0]             fl_last_idx;
      logic [OFFSET_BITS-1:0] fl_off;
      logic                   ch_valid;
      logic [CP_BITS-1:0]     ch_cp;
      logic                   tl_valid;
      logic [OFFSET_BITS-1:0] ch_off;
   } ufd_job_type;

   typedef enum logic [1:0] {
      STG_FLUSH,
      STG_CHAR,
      STG_TAIL
   } ufd_stage_type;

endpackage

/* src/utf8_decoder_with_position.sv */
// utf-8 byte stream decoder with line, column and byte offset tracking
//
// req channel: one raw byte per beat in req_tdata, req_tlast marks the final
// byte of the stream; the last byte flushes any unfinished sequence and puts
// all position state back to line 1, column 1, offset 0
// rsp channel: one decoded character per beat, carrying code point, line,
// column and the offset of its first byte; rsp_tlast is set on the last
// beat caused by a given input byte (a byte may cause zero to four beats)
// bad or cut-short sequences come out as u+fffd, one per byte taken
//
// the front classifies each byte in the cycle it is taken and writes a job
// into a four-entry queue; the back expands jobs into result beats, one per
// cycle, and keeps line and column
// throughput: one byte per cycle while each byte yields at most one beat;
// extra beats from a broken sequence are absorbed by the queue; each beat
// is registered in the queue and then in the output register before
// rsp_tvalid; when rsp_tready is low the output register holds, the queue
// fills and req_tready drops once it is full
// reset: synchronous, active high, empties the queue and clears the decoder and position state
module utf8_decoder_with_position
   import ufd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [BYTE_BITS-1:0]      req_tdata,   // byte_value [7:0]
   input  logic                      req_tlast,   // is_last
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // code_point [20:0], line_number [40:21], column_number [56:41],
   // byte_offset [88:57], zero fill [95:89]
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                      rsp_tlast    // run_last
);

   ufd_job_type push_job;
   ufd_job_type head_job;
   logic        push;
   logic        q_full;
   logic        q_empty;
   logic        q_pop;

   // byte classification and sequence assembly
   ufd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .in_ready (req_tready),
      .q_full   (q_full),
      .push     (push),
      .job      (push_job)
   );

   // decouples byte intake from result delivery
   ufd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .head     (head_job),
      .empty    (q_empty)
   );

   // result expansion, position counters and output register
   ufd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head       (head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/ufd_front.sv */
module ufd_front
   import ufd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [BYTE_BITS-1:0] in_byte,
   input  logic                 in_last,
   output logic                 in_ready,
   input  logic                 q_full,
   output logic                 push,
   output ufd_job_type          job
);

   logic [CP_BITS-1:0]     pc_ff, pc_in;
   logic [2:0]             exp_ff, exp_in;
   logic [1:0]             taken_ff, taken_in;
   logic [OFFSET_BITS-1:0] lead_off_ff, lead_off_in;
   logic [OFFSET_BITS-1:0] byte_cnt_ff, byte_cnt_in;

   logic                   accept;
   logic                   is_cont;
   logic                   fresh;
   logic [1:0]             taken_inc;
   logic [CP_BITS-1:0]     pc_ext;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;

   always_comb begin
      pc_in       = pc_ff;
      exp_in      = exp_ff;
      taken_in    = taken_ff;
      lead_off_in = lead_off_ff;
      byte_cnt_in = (byte_cnt_ff == '1) ? byte_cnt_ff : byte_cnt_ff + 1'b1;
      fresh       = 1'b0;
      is_cont     = (in_byte[7:6] == 2'b10);
      taken_inc   = taken_ff + 2'd1;
      pc_ext      = {pc_ff[CP_BITS-7:0], in_byte[5:0]};

      job             = '0;
      job.is_last     = in_last;
      job.fl_off      = lead_off_ff;
      job.ch_off      = byte_cnt_ff;

      if (exp_ff != LEN_NONE) begin
         if (is_cont) begin
            if (({1'b0, taken_inc} + 3'd1) >= exp_ff) begin
               // sequence complete
               job.ch_valid = 1'b1;
               job.ch_cp    = pc_ext;
               job.ch_off   = lead_off_ff;
               pc_in        = '0;
               exp_in       = LEN_NONE;
               taken_in     = 2'd0;
            end else begin
               pc_in    = pc_ext;
               taken_in = taken_inc;
               if (in_last) begin
                  job.fl_valid    = 1'b1;
                  job.fl_last_idx = taken_inc;
               end
            end
         end else begin
            // broken sequence, then the byte starts over
            job.fl_valid    = 1'b1;
            job.fl_last_idx = taken_ff;
            fresh           = 1'b1;
         end
      end else begin
         fresh = 1'b1;
      end

      if (fresh) begin
         pc_in    = '0;
         exp_in   = LEN_NONE;
         taken_in = 2'd0;
         unique casez (in_byte)
            8'b0???????: begin
               job.ch_valid = 1'b1;
               job.ch_cp    = CP_BITS'(in_byte);
            end
            8'b110?????: begin
               pc_in       = CP_BITS'(in_byte & MASK_LEAD2);
               exp_in      = LEN_TWO;
               lead_off_in = byte_cnt_ff;
               job.tl_valid = in_last;
            end
            8'b1110????: begin
               pc_in       = CP_BITS'(in_byte & MASK_LEAD3);
               exp_in      = LEN_THREE;
               lead_off_in = byte_cnt_ff;
               job.tl_valid = in_last;
            end
            8'b11110???: begin
               pc_in       = CP_BITS'(in_byte & MASK_LEAD4);
               exp_in      = LEN_FOUR;
               lead_off_in = byte_cnt_ff;
               job.tl_valid = in_last;
            end
            default: begin
               job.ch_valid = 1'b1;
               job.ch_cp    = CP_REPL;
            end
         endcase
      end

      if (in_last) begin
         pc_in       = '0;
         exp_in      = LEN_NONE;
         taken_in    = 2'd0;
         lead_off_in = '0;
         byte_cnt_in = '0;
      end

      push = accept && (job.fl_valid || job.ch_valid || job.tl_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff       <= '0;
         exp_ff      <= LEN_NONE;
         taken_ff    <= 2'd0;
         lead_off_ff <= '0;
         byte_cnt_ff <= '0;
      end else if (accept) begin
         pc_ff       <= pc_in;
         exp_ff      <= exp_in;
         taken_ff    <= taken_in;
         lead_off_ff <= lead_off_in;
         byte_cnt_ff <= byte_cnt_in;
      end
   end

endmodule

/* src/ufd_queue.sv */
module ufd_queue
   import ufd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ufd_job_type push_job,
   output logic        full,
   input  logic        pop,
   output ufd_job_type head,
   output logic        empty
);

   ufd_job_type          mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] cnt_ff;

   assign full  = (cnt_ff == QCNT_BITS'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job popped from empty queue");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_BITS'(QDEPTH))
      else $error("queue fill count out of range");
`endif

endmodule

/* src/ufd_back.sv */
module ufd_back
   import ufd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  ufd_job_type               head,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                      rsp_tlast
);

   ufd_stage_type          stage_ff, stage_in;
   logic [1:0]             idx_ff, idx_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COL_BITS-1:0]    col_ff, col_in;

   logic                   rsp_valid_ff;
   logic [CP_BITS-1:0]     out_cp_ff;
   logic [LINE_BITS-1:0]   out_line_ff;
   logic [COL_BITS-1:0]    out_col_ff;
   logic [OFFSET_BITS-1:0] out_off_ff;
   logic                   out_last_ff;

   logic                   sel_fl, sel_ch, sel_tl;
   logic                   load, emit, job_done;
   logic [OFFSET_BITS:0]   fl_sum;
   logic [OFFSET_BITS-1:0] res_off;
   logic [CP_BITS-1:0]     res_cp;

   always_comb begin
      sel_fl = 1'b0;
      sel_ch = 1'b0;
      unique case (stage_ff)
         STG_FLUSH: begin
            sel_fl = head.fl_valid;
            sel_ch = !head.fl_valid && head.ch_valid;
         end
         STG_CHAR: begin
            sel_ch = head.ch_valid;
         end
         STG_TAIL: begin
            sel_ch = 1'b0;
         end
         default: begin
            sel_ch = 1'b0;
         end
      endcase
      sel_tl = !sel_fl && !sel_ch && head.tl_valid;

      load = !rsp_valid_ff || rsp_tready;
      emit = !q_empty && load;

      // flushed continuation bytes sit at lead offset plus index
      fl_sum  = {1'b0, head.fl_off} + (OFFSET_BITS + 1)'(idx_ff);
      res_off = sel_fl ? (fl_sum[OFFSET_BITS] ? '1 : fl_sum[OFFSET_BITS-1:0])
                       : head.ch_off;
      res_cp  = sel_ch ? head.ch_cp : CP_REPL;

      if (sel_fl) begin
         job_done = (idx_ff == head.fl_last_idx) && !head.ch_valid && !head.tl_valid;
      end else if (sel_ch) begin
         job_done = !head.tl_valid;
      end else begin
         job_done = 1'b1;
      end

      stage_in = stage_ff;
      idx_in   = idx_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      if (emit) begin
         if (job_done) begin
            stage_in = STG_FLUSH;
            idx_in   = 2'd0;
         end else if (sel_fl) begin
            if (idx_ff == head.fl_last_idx) begin
               stage_in = STG_CHAR;
               idx_in   = 2'd0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end else begin
            stage_in = STG_TAIL;
         end

         if (res_cp == CP_NEWLINE) begin
            line_in = (line_ff == '1) ? line_ff : line_ff + 1'b1;
            col_in  = COL_BITS'(1);
         end else begin
            col_in = (col_ff == '1) ? col_ff : col_ff + 1'b1;
         end

         // end of stream puts position back to the start
         if (job_done && head.is_last) begin
            line_in = LINE_BITS'(1);
            col_in  = COL_BITS'(1);
         end
      end

      q_pop = emit && job_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= STG_FLUSH;
         idx_ff       <= 2'd0;
         line_ff      <= LINE_BITS'(1);
         col_ff       <= COL_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         idx_ff   <= idx_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         if (load) begin
            rsp_valid_ff <= !q_empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_cp_ff   <= res_cp;
         out_line_ff <= line_ff;
         out_col_ff  <= col_ff;
         out_off_ff  <= res_off;
         out_last_ff <= job_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, out_off_ff, out_col_ff, out_line_ff, out_cp_ff};

`ifndef SYNTHESIS
   a_job_has_work: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (sel_fl || sel_ch || sel_tl))
      else $error("queued job with nothing left to emit");

   a_mid_job_held: assert property (@(posedge clock) disable iff (reset)
      (stage_ff != STG_FLUSH) |-> !q_empty)
      else $error("job sequencer mid-job with empty queue");

   a_stream_end_pos: assert property (@(posedge clock) disable iff (reset)
      (q_pop && head.is_last) |=> (line_ff == LINE_BITS'(1) && col_ff == COL_BITS'(1)))
      else $error("position not reset at end of stream");
`endif

endmodule

/* test/utf8_decoder_with_position_tb.sv */
`timescale 1ns / 100ps

module utf8_decoder_with_position_tb;
   import ufd_pkg::*;

   localparam int RAND_ITEMS  = 145;
   localparam int TAIL_CYCLES = 8;       // margin after the last owed character
   localparam int CYCLE_LIMIT = 1000000;

   localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam logic [COL_BITS-1:0]    COL_MAX  = '1;

   // one decoded character as it leaves the block
   typedef struct packed {
      logic [CP_BITS-1:0]     cp;
      logic [LINE_BITS-1:0]   line_no;
      logic [COL_BITS-1:0]    col_no;
      logic [OFFSET_BITS-1:0] offset;
      logic                   run_last;
   } char_rec_type;

   localparam char_rec_type NO_CHAR = '0;

   // directed byte with an optional hand-written result
   typedef struct {
      logic [7:0]   data;
      logic         last;
      logic         typed;
      char_rec_type want;
   } stim_row_type;

   localparam int DIR_ROWS = 26;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [BYTE_BITS-1:0]      req_tdata  = '0;   // byte_value [7:0]
   logic                      req_tlast  = 1'b0; // is_last
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // code_point [20:0], line_number [40:21], column_number [56:41],
   // byte_offset [88:57], zero fill [95:89]
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tlast;        // run_last

   // decoder state mirrored on the bench side
   logic [CP_BITS-1:0]     seq_code;
   logic [2:0]             seq_len;
   logic [1:0]             seq_taken;
   logic [OFFSET_BITS-1:0] seq_off;
   logic [OFFSET_BITS-1:0] byte_count;
   logic [LINE_BITS-1:0]   cur_line;
   logic [COL_BITS-1:0]    cur_col;

   char_rec_type step_chars[$];      // characters caused by the byte being decoded
   char_rec_type expected_chars[$];  // characters still owed by the block
   char_rec_type got_char;
   char_rec_type want_char;

   logic calm = 1'b0;             // no idling on either side while set
   int   fail_count    = 0;
   int   bytes_sent    = 0;
   int   chars_checked = 0;
   int   cycle_count   = 0;

   // bytes 0..18 run on one stream, 18 ends it with a completed two-byte
   // character, 21 cuts a sequence short, 25 breaks a four-byte lead with
   // a newline that also ends the stream (four beats from one byte)
   stim_row_type directed_bytes [DIR_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, '{21'h000000, 20'd1, 16'd1, 32'd0,  1'b1}},
      '{8'h0A, 1'b0, 1'b1, '{21'h00000A, 20'd1, 16'd2, 32'd1,  1'b1}},
      '{8'hE2, 1'b0, 1'b0, NO_CHAR},
      '{8'h82, 1'b0, 1'b0, NO_CHAR},
      '{8'hAC, 1'b0, 1'b0, NO_CHAR},
      '{8'hF7, 1'b0, 1'b0, NO_CHAR},
      '{8'hBF, 1'b0, 1'b0, NO_CHAR},
      '{8'hBF, 1'b0, 1'b0, NO_CHAR},
      '{8'hBF, 1'b0, 1'b0, NO_CHAR},
      '{8'h80, 1'b0, 1'b1, '{21'h00FFFD, 20'd2, 16'd3, 32'd9,  1'b1}},
      '{8'hFF, 1'b0, 1'b1, '{21'h00FFFD, 20'd2, 16'd4, 32'd10, 1'b1}},
      '{8'hE0, 1'b0, 1'b0, NO_CHAR},
      '{8'h80, 1'b0, 1'b0, NO_CHAR},
      '{8'h41, 1'b0, 1'b0, NO_CHAR},
      '{8'hF0, 1'b0, 1'b0, NO_CHAR},
      '{8'h80, 1'b0, 1'b0, NO_CHAR},
      '{8'h80, 1'b0, 1'b0, NO_CHAR},
      '{8'hC2, 1'b0, 1'b0, NO_CHAR},
      '{8'h80, 1'b1, 1'b0, NO_CHAR},
      '{8'h42, 1'b0, 1'b1, '{21'h000042, 20'd1, 16'd1, 32'd0,  1'b1}},
      '{8'hE1, 1'b0, 1'b0, NO_CHAR},
      '{8'h80, 1'b1, 1'b0, NO_CHAR},
      '{8'hF4, 1'b0, 1'b0, NO_CHAR},
      '{8'h8F, 1'b0, 1'b0, NO_CHAR},
      '{8'hBF, 1'b0, 1'b0, NO_CHAR},
      '{8'h0A, 1'b1, 1'b0, NO_CHAR}
   };

   utf8_decoder_with_position DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // decoder prediction
   // ---------------------------------------------------------------

   task automatic clear_decoder();
      seq_code   = '0;
      seq_len    = LEN_NONE;
      seq_taken  = '0;
      seq_off    = '0;
      byte_count = '0;
      cur_line   = LINE_BITS'(1);
      cur_col    = COL_BITS'(1);
   endtask

   // hand out one character at the current position, then move the position
   task automatic issue_char(input logic [CP_BITS-1:0] cp, input logic [OFFSET_BITS-1:0] off);
      char_rec_type rec;
      rec = '{cp, cur_line, cur_col, off, 1'b0};
      step_chars = {step_chars, rec};
      if (cp == CP_NEWLINE) begin
         if (cur_line != LINE_MAX) cur_line = cur_line + 1'b1;
         cur_col = COL_BITS'(1);
      end else if (cur_col != COL_MAX) begin
         cur_col = cur_col + 1'b1;
      end
   endtask

   // one replacement for the lead, then one per continuation already taken
   task automatic flush_seq();
      issue_char(CP_REPL, seq_off);
      for (int k = 1; k <= seq_taken; k++) begin
         if (seq_off > OFF_MAX - OFFSET_BITS'(k)) issue_char(CP_REPL, OFF_MAX);
         else issue_char(CP_REPL, seq_off + OFFSET_BITS'(k));
      end
      seq_code  = '0;
      seq_len   = LEN_NONE;
      seq_taken = '0;
   endtask

   // byte seen with nothing pending: plain character, lead, or rubbish
   task automatic start_char(input logic [7:0] b, input logic [OFFSET_BITS-1:0] off);
      if (!b[7]) begin
         issue_char(CP_BITS'(b), off);
      end else begin
         if (b[7:5] == 3'b110) begin
            seq_code = CP_BITS'(b & MASK_LEAD2);
            seq_len  = LEN_TWO;
         end else if (b[7:4] == 4'b1110) begin
            seq_code = CP_BITS'(b & MASK_LEAD3);
            seq_len  = LEN_THREE;
         end else if (b[7:3] == 5'b11110) begin
            seq_code = CP_BITS'(b & MASK_LEAD4);
            seq_len  = LEN_FOUR;
         end else begin
            // stray continuation or f8-ff
            issue_char(CP_REPL, off);
         end
         if (seq_len != LEN_NONE) begin
            seq_taken = '0;
            seq_off   = off;
         end
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic [OFFSET_BITS-1:0] off;
      off = byte_count;
      if (byte_count != OFF_MAX) byte_count = byte_count + 1'b1;
      step_chars.delete();
      if (seq_len != LEN_NONE) begin
         if (b[7:6] == 2'b10) begin
            seq_code  = {seq_code[CP_BITS-7:0], b[5:0]};
            seq_taken = seq_taken + 2'd1;
            if ({1'b0, seq_taken} + 3'd1 >= seq_len) begin
               issue_char(seq_code, seq_off);
               seq_code  = '0;
               seq_len   = LEN_NONE;
               seq_taken = '0;
            end
         end else begin
            flush_seq();
            start_char(b, off);
         end
      end else begin
         start_char(b, off);
      end
      // end of stream: flush whatever is open and start over
      if (last) begin
         if (seq_len != LEN_NONE) flush_seq();
         clear_decoder();
      end
      if (step_chars.size() != 0) step_chars[step_chars.size()-1].run_last = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // drive one byte, wait for its beat, then owe whatever it decodes to
   task automatic send_byte(input logic [7:0] b, input logic last,
                            input logic typed = 1'b0, input char_rec_type typed_char = '0);
      while (!calm && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      decode_byte(b, last);
      if (typed) begin
         expected_chars = {expected_chars, typed_char};
      end else begin
         expected_chars = {expected_chars, step_chars};
      end
   endtask

   // hold the request side quiet until every owed character has come back
   task automatic drain(input int extra);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_chars.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   function automatic logic [7:0] lead_byte(input int n);
      case (n)
         2:       return 8'hC0 | 8'($urandom_range(0, 31));
         3:       return 8'hE0 | 8'($urandom_range(0, 15));
         default: return 8'hF0 | 8'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 25);
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_char.cp       = rsp_tdata[CP_BITS-1:0];
         got_char.line_no  = rsp_tdata[CP_BITS +: LINE_BITS];
         got_char.col_no   = rsp_tdata[CP_BITS+LINE_BITS +: COL_BITS];
         got_char.offset   = rsp_tdata[CP_BITS+LINE_BITS+COL_BITS +: OFFSET_BITS];
         got_char.run_last = rsp_tlast;
         if (expected_chars.size() == 0) begin
            fail_count++;
            $error("unexpected character 0x%0h at offset %0d", got_char.cp, got_char.offset);
         end else begin
            want_char = expected_chars.pop_front();
            check_field("code_point",    32'(want_char.cp),       32'(got_char.cp));
            check_field("line_number",   32'(want_char.line_no),  32'(got_char.line_no));
            check_field("column_number", 32'(want_char.col_no),   32'(got_char.col_no));
            check_field("byte_offset",   want_char.offset,        got_char.offset);
            check_field("run_last",      32'(want_char.run_last), 32'(got_char.run_last));
            chars_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out with %0d characters outstanding", expected_chars.size());
         $display("FAIL utf8_decoder_with_position");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   initial begin : stimulus
      int  kind;
      int  n;
      int  k;
      logic cut;
      logic paused;

      paused = 1'b0;
      clear_decoder();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, each sequence length, bad bytes, broken and cut runs
      foreach (directed_bytes[i])
         send_byte(directed_bytes[i].data, directed_bytes[i].last,
                   directed_bytes[i].typed, directed_bytes[i].want);
      drain(0);

      // random: mostly well-formed text with random content, then rubbish,
      // broken sequences and stream ends sprinkled in
      while (bytes_sent < DIR_ROWS + RAND_ITEMS) begin
         calm = (bytes_sent >= DIR_ROWS + 100) && (bytes_sent < DIR_ROWS + 140);
         // one full stop on the sender mid-run, so the pipeline runs dry
         if (!paused && bytes_sent >= DIR_ROWS + 70) begin
            drain(0);
            paused = 1'b1;
         end
         kind = $urandom_range(0, 19);
         if (kind < 7) begin
            send_byte(($urandom_range(0, 4) == 0) ? 8'h0A : 8'($urandom_range(0, 127)), 1'b0);
         end else if (kind < 14) begin
            n = $urandom_range(2, 4);
            send_byte(lead_byte(n), 1'b0);
            for (int j = 1; j < n; j++) send_byte(cont_byte(), 1'b0);
         end else if (kind < 16) begin
            // lead plus too few continuations, broken by the next byte or cut off
            n   = $urandom_range(2, 4);
            k   = $urandom_range(0, n - 2);
            cut = ($urandom_range(0, 2) == 0);
            send_byte(lead_byte(n), cut && (k == 0));
            for (int j = 0; j < k; j++) send_byte(cont_byte(), cut && (j == k - 1));
         end else if (kind < 19) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end else begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
         end
      end
      calm = 1'b0;

      drain(TAIL_CYCLES);
      if (expected_chars.size() != 0) begin
         fail_count++;
         $error("%0d characters never arrived", expected_chars.size());
      end

      $display("sent %0d bytes and checked %0d characters, %0d mismatches",
               bytes_sent, chars_checked, fail_count);
      $display("covered plain, multi-byte, stray, broken and cut sequences, stream ends,"
               , " stalls on both sides and a drained pipeline");
      if (fail_count == 0) begin
         $display("PASS utf8_decoder_with_position");
      end else begin
         $display("FAIL utf8_decoder_with_position");
      end
      $finish;
   end

endmodule

/* utf8_decoder_with_position.f */
src/ufd_pkg.sv
src/ufd_front.sv
src/ufd_queue.sv
src/ufd_back.sv
src/utf8_decoder_with_position.sv
test/utf8_decoder_with_position_tb.sv
